FILE: rtl/ksta_pkg.sv
`timescale 1ns / 1ps

package ksta_pkg;

  localparam int ENTRIES  = 32;
  localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int KEY_W    = 22;
  localparam int TOTAL_W  = 64;
  localparam int STATUS_W = 2;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_EXISTING = 2'd0,
    ST_NEW      = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  // Outcome of one key search
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             fresh;
    logic             full;
  } lkp_res_t;

endpackage

FILE: rtl/keyed_sleep_time_accumulator.sv
`timescale 1ns / 1ps
// Each input word passes S_LOOK (key search with the total read), then S_UPD
//   (the read-modify-write), where its result word is registered; words never
//   overlap, and a result word left waiting on out_ready holds the update and
//   the input until it drains.
// Reset: synchronous, active low; clears every valid mark and all handshake state.
//   Keys and totals are not cleared: an entry is written whole when claimed.

module keyed_sleep_time_accumulator import ksta_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_cmd,
  input  logic [KEY_W-1:0]    in_proc_key,
  input  logic [TOTAL_W-1:0]  in_amount_ns,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TOTAL_W-1:0]  out_total_ns,
  output logic [STATUS_W-1:0] out_status
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_UPD
  } state_t;

  state_t               state_r;
  logic                 cmd_r;
  logic [KEY_W-1:0]     key_r;
  logic [TOTAL_W-1:0]   amount_r;
  lkp_res_t             res;
  lkp_res_t             res_r;
  logic                 out_valid_r;
  logic [TOTAL_W-1:0]   total_r;
  logic [STATUS_W-1:0]  status_r;

  logic                 look;
  logic                 out_free;
  logic                 upd_fire;
  logic                 in_fire;
  logic [TOTAL_W-1:0]   rd_total;
  logic [TOTAL_W-1:0]   base;
  logic [TOTAL_W-1:0]   sum_nxt;
  logic [STATUS_W-1:0]  status_nxt;

  // The output register is free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ready;
  assign look     = (state_r == S_LOOK);
  assign upd_fire = (state_r == S_UPD) && out_free;
  // Take a new word when idle, or in the same cycle the current one retires
  assign in_ready = (state_r == S_IDLE) || upd_fire;
  assign in_fire  = in_valid && in_ready;

  ksta_lookup u_lookup (
    .clk   (clk),
    .rst_n (rst_n),
    .look  (look),
    .key   (key_r),
    .res   (res)
  );

  // Read the entry's total during the search; write it back in S_UPD once the output is free.
  // A following word reads no earlier than the edge after that write, so no
  // forwarding path is needed.
  ksta_total_ram u_total_ram (
    .clk   (clk),
    .we    (upd_fire && !res_r.full),
    .waddr (res_r.idx),
    .wdata (sum_nxt),
    .re    (look),
    .raddr (res.idx),
    .rdata (rd_total)
  );

  // A freshly claimed entry starts from zero; a query adds nothing
  always_comb begin
    base    = res_r.fresh ? '0 : rd_total;
    sum_nxt = (cmd_r == CMD_ADD) ? base + amount_r : base;
    priority if (res_r.full) begin
      status_nxt = ST_FULL;
    end else if (res_r.fresh) begin
      status_nxt = ST_NEW;
    end else begin
      status_nxt = ST_EXISTING;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          // Hold here while the previous result word is still waiting
          if (upd_fire) begin
            state_r <= in_fire ? S_LOOK : S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (upd_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r    <= in_cmd;
      key_r    <= in_proc_key;
      amount_r <= in_amount_ns;
    end
    if (look) begin
      res_r <= res;
    end
    if (upd_fire) begin
      total_r  <= res_r.full ? '0 : sum_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_total_ns = total_r;
  assign out_status   = status_r;

endmodule

FILE: rtl/ksta_lookup.sv
`timescale 1ns / 1ps

// Key table: valid marks and keys in flops, searched in parallel.
module ksta_lookup import ksta_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             look,
  input  logic [KEY_W-1:0] key,
  output lkp_res_t         res
);

  logic [ENTRIES-1:0] valid_r;
  logic [KEY_W-1:0]   key_r [ENTRIES];
  logic [ENTRIES-1:0] match;
  logic               hit;
  logic               free_any;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   free_idx;

  always_comb begin
    hit      = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid_r[i] && (key_r[i] == key);
    end
    // Walk downwards so the lowest-numbered entry wins
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
    res.idx   = hit ? hit_idx : free_idx;
    res.fresh = !hit && free_any;
    res.full  = !hit && !free_any;
  end

  // Claim the first free entry on a miss
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (look && res.fresh) begin
      valid_r[res.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (look && res.fresh) begin
      key_r[res.idx] <= key;
    end
  end

endmodule

FILE: rtl/ksta_total_ram.sv
`timescale 1ns / 1ps

// Running totals: one write port, one read port, registered read data.
module ksta_total_ram import ksta_pkg::*; (
  input  logic               clk,
  input  logic               we,
  input  logic [IDX_W-1:0]   waddr,
  input  logic [TOTAL_W-1:0] wdata,
  input  logic               re,
  input  logic [IDX_W-1:0]   raddr,
  output logic [TOTAL_W-1:0] rdata
);

  logic [TOTAL_W-1:0] mem [ENTRIES];
  logic [TOTAL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
